// ----- hw/rtl/rgb_led_blink_controller_core_macros.svh -----
// ----------------------------------------------------------------------------
// RGB light controller assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_BLINK_CONTROLLER_CORE_MACROS_SVH
`define RGB_LED_BLINK_CONTROLLER_CORE_MACROS_SVH

// Condition holds at every edge outside reset
`define RLBC_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define RLBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/rlbc_pkg.sv -----
// ----------------------------------------------------------------------------
// rlbc_pkg
// Shared types and constants of the RGB light blink controller.
// ----------------------------------------------------------------------------
package rlbc_pkg;

  localparam int LIGHT_COUNT_DEFAULT = 8;
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W = 16;

  localparam logic [DIVISOR_W-1:0] PERIOD_RESET = 16'd500;

  typedef logic [23:0] color_t;
  localparam color_t COLOR_BLACK = 24'h000000;
  localparam color_t COLOR_BLUE  = 24'h0000FF;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_MODE  = 2'd1,
    OP_SET_COLOR = 2'd2,
    OP_TOGGLE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_OTHER = 2'd3
  } mode_t;

  // One light: mode, remembered color, displayed color
  typedef struct packed {
    mode_t  mode;
    color_t stored;
    color_t disp;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{mode: MODE_OFF, stored: COLOR_BLUE, disp: COLOR_BLACK};

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic q_lsb;
  } div_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD_RD,
    ST_CMD_MOD,
    ST_DIV,
    ST_FRAME_RD,
    ST_FRAME_MOD,
    ST_FRAME_OUT,
    ST_ERR_OUT
  } state_t;

endpackage

// ----- hw/rtl/rlbc_div.sv -----
// ----------------------------------------------------------------------------
// rlbc_div
// Bit-serial restoring divider, one quotient bit per cycle; reports the
// quotient's low bit (the blink phase).
// ----------------------------------------------------------------------------
module rlbc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rlbc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [rlbc_pkg::DIVISOR_W-1:0]  divisor,
  output rlbc_pkg::div_status_t       status
);
  import rlbc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W-1:0]  rem;
  logic                  qbit;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;

  // one restoring step
  always_comb begin
    trial    = {rem, dvd[DIVIDEND_W-1]};
    ge       = (trial >= {1'b0, dsr});
    diff     = trial - {1'b0, dsr};
    rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath; zero period acts as one
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= (divisor == '0) ? DIVISOR_W'(1) : divisor;
      rem <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      dvd  <= {dvd[DIVIDEND_W-2:0], 1'b0};
      qbit <= ge;
    end
  end

  assign status.done  = done;
  assign status.q_lsb = qbit;

endmodule

// ----- hw/rtl/rlbc_store.sv -----
// ----------------------------------------------------------------------------
// rlbc_store
// Per-light state memory, one write and one registered read port. Entries
// never written read as the reset entry through per-entry valid bits.
// ----------------------------------------------------------------------------
module rlbc_store #(
  parameter int LIGHT_COUNT = rlbc_pkg::LIGHT_COUNT_DEFAULT,
  parameter int LIGHT_W = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [LIGHT_W-1:0]   rd_addr,
  output rlbc_pkg::entry_t     rd_entry,
  input  logic                 wr_en,
  input  logic [LIGHT_W-1:0]   wr_addr,
  input  rlbc_pkg::entry_t     wr_entry
);
  import rlbc_pkg::*;

  entry_t               mem [LIGHT_COUNT];
  logic [LIGHT_COUNT-1:0] vld;
  entry_t               rd_q;
  logic                 rd_ok;

  // valid bits and read-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) vld[wr_addr] <= 1'b1;
      if (rd_en) rd_ok <= vld[rd_addr];
    end
  end

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign rd_entry = rd_ok ? rd_q : RESET_ENTRY;

endmodule

// ----- hw/rtl/rgb_led_blink_controller_core.sv -----
// Command: out-of-range light gives its error result in the cycle after accept;
// a valid command reads, then updates its light, then a frame unless it sets blink or the inert mode.
// Frame: per light a read, an update and a present step, plus output stall time.
// Tick: divide in the bit-serial divider if any light blinks, then a frame on phase flip.
// One transaction in flight; sync reset restores period 500, flag and lights.
// Light state comes out of reset through valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// rgb_led_blink_controller_core
// Multi-light RGB controller with on, off and blink modes, frame output.
// ----------------------------------------------------------------------------
`include "rgb_led_blink_controller_core_macros.svh"

module rgb_led_blink_controller_core #(
  parameter int LIGHT_COUNT = rlbc_pkg::LIGHT_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  light,
  input  logic [1:0]  mode_value,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_light,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        bad_light,
  output logic        frame_last
);
  import rlbc_pkg::*;

  localparam int LIGHT_W = (LIGHT_COUNT > 1) ? $clog2(LIGHT_COUNT) : 1;
  localparam logic [LIGHT_W-1:0] LAST_IDX = LIGHT_W'(LIGHT_COUNT - 1);
  localparam logic [5:0] LAST_OUT = 6'(LIGHT_COUNT - 1);

  state_t state, state_next;

  logic [DIVISOR_W-1:0]   period;
  logic                   flag;
  logic                   toggle_all;
  logic [LIGHT_W-1:0]     idx;
  logic [LIGHT_COUNT-1:0] blink_vec;

  op_t                op_q;
  logic [LIGHT_W-1:0] light_q;
  mode_t              mode_q;
  color_t             color_q;

  logic               accept;
  logic               in_bad;
  logic               any_blink;
  logic               out_take;

  logic               rd_en;
  logic [LIGHT_W-1:0] rd_addr;
  entry_t             rd_entry;
  logic               wr_en;
  logic [LIGHT_W-1:0] wr_addr;
  entry_t             wr_entry;

  logic               div_start;
  div_status_t        div_st;

  entry_t             cmd_entry;
  logic               cmd_frame;
  entry_t             frm_entry;
  logic [9:0]         sum;

  // single-light toggle
  function automatic entry_t toggle_entry(entry_t e);
    entry_t r;
    r = e;
    case (e.mode)
      MODE_ON: begin
        r.disp = COLOR_BLACK;
        r.mode = MODE_OFF;
      end
      MODE_OFF: begin
        r.disp = e.stored;
        r.mode = MODE_ON;
      end
      MODE_BLINK: begin
        r.disp = (e.disp == e.stored) ? COLOR_BLACK : e.stored;
      end
      default: begin
        r = e;
      end
    endcase
    return r;
  endfunction

  // divider for the blink phase
  rlbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (now_ms),
    .divisor  (period),
    .status   (div_st)
  );

  // light state memory
  rlbc_store #(
    .LIGHT_COUNT (LIGHT_COUNT),
    .LIGHT_W     (LIGHT_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  // handshake terms
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_bad    = (light >= 8'(LIGHT_COUNT));
  assign any_blink = |blink_vec;

  // command update of the addressed light, frame update of the current light
  always_comb begin
    sum       = 10'(color_q[23:16]) + 10'(color_q[15:8]) + 10'(color_q[7:0]);
    cmd_entry = rd_entry;
    cmd_frame = 1'b1;
    case (op_q)
      OP_SET_MODE: begin
        cmd_entry.mode = mode_q;
        if (mode_q == MODE_ON) cmd_entry.disp = rd_entry.stored;
        else if (mode_q == MODE_OFF) cmd_entry.disp = COLOR_BLACK;
        else cmd_frame = 1'b0;
      end
      OP_SET_COLOR: begin
        cmd_entry.stored = color_q;
        cmd_entry.disp   = color_q;
        if (rd_entry.mode != MODE_BLINK)
          cmd_entry.mode = (sum > 10'd1) ? MODE_ON : MODE_OFF;
      end
      OP_TOGGLE: begin
        cmd_entry = toggle_entry(rd_entry);
      end
      default: begin
        cmd_frame = 1'b0;
      end
    endcase
    frm_entry = (toggle_all && rd_entry.mode == MODE_BLINK) ? toggle_entry(rd_entry)
                                                             : rd_entry;
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_entry   = frm_entry;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op_t'(op) == OP_TICK) begin
            if (any_blink) begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end else if (in_bad) begin
            state_next = ST_ERR_OUT;
          end else begin
            state_next = ST_CMD_RD;
          end
        end
      end
      ST_CMD_RD: begin
        rd_en      = 1'b1;
        rd_addr    = light_q;
        state_next = ST_CMD_MOD;
      end
      ST_CMD_MOD: begin
        wr_en      = 1'b1;
        wr_addr    = light_q;
        wr_entry   = cmd_entry;
        state_next = cmd_frame ? ST_FRAME_RD : ST_IDLE;
      end
      ST_DIV: begin
        if (div_st.done) state_next = (div_st.q_lsb == flag) ? ST_IDLE : ST_FRAME_RD;
      end
      ST_FRAME_RD: begin
        rd_en      = 1'b1;
        state_next = ST_FRAME_MOD;
      end
      ST_FRAME_MOD: begin
        wr_en      = toggle_all;
        state_next = ST_FRAME_OUT;
      end
      ST_FRAME_OUT: begin
        if (out_take) state_next = frame_last ? ST_IDLE : ST_FRAME_RD;
      end
      ST_ERR_OUT: begin
        if (out_take) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= PERIOD_RESET;
      flag       <= 1'b0;
      toggle_all <= 1'b0;
      idx        <= '0;
      blink_vec  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) period <= cfg_data;
      if (accept && op_t'(op) != OP_TICK && in_bad) out_valid <= 1'b1;
      if (state == ST_CMD_MOD) begin
        blink_vec[light_q] <= (cmd_entry.mode == MODE_BLINK);
        idx        <= '0;
        toggle_all <= 1'b0;
      end
      if (state == ST_DIV && div_st.done && div_st.q_lsb != flag) begin
        flag       <= div_st.q_lsb;
        toggle_all <= 1'b1;
        idx        <= '0;
      end
      if (state == ST_FRAME_MOD) out_valid <= 1'b1;
      if (out_take) begin
        out_valid <= 1'b0;
        if (state == ST_FRAME_OUT && !frame_last) idx <= idx + 1'b1;
      end
    end
  end

  // transaction capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(op);
      light_q <= light[LIGHT_W-1:0];
      mode_q  <= mode_t'(mode_value);
      color_q <= {red, green, blue};
      if (op_t'(op) != OP_TICK && in_bad) begin
        out_light  <= '0;
        out_red    <= '0;
        out_green  <= '0;
        out_blue   <= '0;
        bad_light  <= 1'b1;
        frame_last <= 1'b1;
      end
    end
    if (state == ST_FRAME_MOD) begin
      out_light  <= 6'(idx);
      out_red    <= frm_entry.disp[23:16];
      out_green  <= frm_entry.disp[15:8];
      out_blue   <= frm_entry.disp[7:0];
      bad_light  <= 1'b0;
      frame_last <= (idx == LAST_IDX);
    end
  end

  // checks
  `RLBC_ASSERT(a_err_is_last, !(out_valid && bad_light) || frame_last, "error result not last")
  `RLBC_ASSERT(a_ready_no_result, in_stall || !out_valid, "input taken with a result pending")
  `RLBC_ASSERT_NEXT(a_last_to_idle, out_valid && !out_stall && frame_last, !in_stall, "not ready after last result")
  `RLBC_ASSERT(a_light_in_range, !out_valid || (out_light <= LAST_OUT), "reported light out of range")

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB light blink controller: drives commands,
// ticks and period writes, predicts every reported frame, compares results.
// ----------------------------------------------------------------------------
import rlbc_pkg::*;

// One command transaction as offered on the input channel
typedef struct packed {
  op_t         op;
  logic [7:0]  light;
  mode_t       mv;
  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;
  logic [31:0] now;
} cmd_t;

// One reported pixel of a frame, or an error result
typedef struct packed {
  logic [5:0] idx;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic       bad;
  logic       last;
} pixel_t;

// Tracks light state and the pixels the block still owes
class light_frame_scoreboard;
  localparam int LIGHTS = LIGHT_COUNT_DEFAULT;

  color_t      shown [LIGHTS];
  color_t      kept [LIGHTS];
  mode_t       mode [LIGHTS];
  bit          phase_flag;
  logic [15:0] period;
  pixel_t      pending [$];
  int          errors;

  function new();
    for (int i = 0; i < LIGHTS; i++) begin
      shown[i] = COLOR_BLACK;
      kept[i]  = COLOR_BLUE;
      mode[i]  = MODE_OFF;
    end
    phase_flag = 0;
    period = PERIOD_RESET;
    errors = 0;
  endfunction

  function void set_period(logic [15:0] p);
    period = p;
  endfunction

  // Whole display, index order, last flag on the final light
  function void push_frame();
    for (int i = 0; i < LIGHTS; i++)
      pending.push_back('{idx: 6'(i), r: shown[i][23:16], g: shown[i][15:8],
                          b: shown[i][7:0], bad: 1'b0, last: (i == LIGHTS - 1)});
  endfunction

  function void toggle_light(int i);
    case (mode[i])
      MODE_ON: begin
        shown[i] = COLOR_BLACK;
        mode[i]  = MODE_OFF;
      end
      MODE_OFF: begin
        shown[i] = kept[i];
        mode[i]  = MODE_ON;
      end
      MODE_BLINK: begin
        shown[i] = (shown[i] == kept[i]) ? COLOR_BLACK : kept[i];
      end
      default: ;
    endcase
  endfunction

  // Update state for an accepted command and queue what it reports
  function void note_command(cmd_t c);
    bit          any;
    logic [15:0] eff;
    logic [31:0] quo;
    logic [9:0]  sum;
    int          n;
    n = int'(c.light);
    if (c.op == OP_TICK) begin
      any = 0;
      for (int i = 0; i < LIGHTS; i++)
        if (mode[i] == MODE_BLINK) any = 1;
      if (!any) return;
      eff = (period == 0) ? 16'd1 : period;
      quo = c.now / {16'd0, eff};
      if (quo[0] == phase_flag) return;
      phase_flag = quo[0];
      for (int i = 0; i < LIGHTS; i++)
        if (mode[i] == MODE_BLINK) toggle_light(i);
      push_frame();
      return;
    end
    // out-of-range light: single error result, nothing changes
    if (n >= LIGHTS) begin
      pending.push_back('{idx: 6'd0, r: 8'd0, g: 8'd0, b: 8'd0, bad: 1'b1, last: 1'b1});
      return;
    end
    case (c.op)
      OP_SET_MODE: begin
        mode[n] = c.mv;
        if (c.mv == MODE_ON || c.mv == MODE_OFF) begin
          shown[n] = (c.mv == MODE_ON) ? kept[n] : COLOR_BLACK;
          push_frame();
        end
      end
      OP_SET_COLOR: begin
        shown[n] = {c.r, c.g, c.b};
        kept[n]  = {c.r, c.g, c.b};
        sum = c.r + c.g + c.b;
        if (mode[n] != MODE_BLINK) mode[n] = (sum > 1) ? MODE_ON : MODE_OFF;
        push_frame();
      end
      default: begin
        toggle_light(n);
        push_frame();
      end
    endcase
  endfunction

  task report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task check_pixel(pixel_t got);
    pixel_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result for light %0d", got.idx));
      return;
    end
    want = pending.pop_front();
    if (got.idx != want.idx)
      report($sformatf("out_light %0d, want %0d", got.idx, want.idx));
    if (got.r != want.r)
      report($sformatf("light %0d red %0h, want %0h", want.idx, got.r, want.r));
    if (got.g != want.g)
      report($sformatf("light %0d green %0h, want %0h", want.idx, got.g, want.g));
    if (got.b != want.b)
      report($sformatf("light %0d blue %0h, want %0h", want.idx, got.b, want.b));
    if (got.bad != want.bad)
      report($sformatf("light %0d bad_light %0b, want %0b", want.idx, got.bad, want.bad));
    if (got.last != want.last)
      report($sformatf("light %0d frame_last %0b, want %0b", want.idx, got.last, want.last));
  endtask
endclass

module tb;
  localparam int LIGHTS = LIGHT_COUNT_DEFAULT;
  localparam int STALL_LIMIT = 2000;   // cycles with no transaction at all
  localparam int SETTLE = 60;          // covers a tick's divide plus slack
  localparam int HOLD = 300;           // long output back-pressure stretch
  localparam int PHASE_ITEMS = 36;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [7:0]  light;
  logic [1:0]  mode_value;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_light;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        bad_light;
  logic        frame_last;

  light_frame_scoreboard sb;
  bit          send_idle;
  bit          take_idle;
  bit          hold_req;
  logic [31:0] wall_ms;
  int          quiet_cycles;

  rgb_led_blink_controller_core #(.LIGHT_COUNT(LIGHTS)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .light(light), .mode_value(mode_value),
    .red(red), .green(green), .blue(blue), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_light(out_light), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .bad_light(bad_light), .frame_last(frame_last)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic cmd_t cmd_of(op_t o, int l, mode_t m, int r, int g, int b,
                                  logic [31:0] t);
    cmd_t c;
    c = '{op: o, light: 8'(l), mv: m, r: 8'(r), g: 8'(g), b: 8'(b), now: t};
    return c;
  endfunction

  // Mostly well-formed traffic on valid lights, time advancing near the period
  function automatic cmd_t random_command(logic [15:0] p);
    cmd_t c;
    int   pick;
    int   eff;
    pick = $urandom_range(0, 99);
    eff = (p == 0) ? 1 : int'(p);
    wall_ms = wall_ms + 32'($urandom_range(0, 2 * eff + 1));
    c.now = ($urandom_range(0, 9) == 0) ? 32'($urandom) : wall_ms;
    c.light = 8'($urandom_range(0, LIGHTS - 1));
    c.mv = mode_t'($urandom_range(0, 3));
    c.r = 8'($urandom_range(0, 255));
    c.g = 8'($urandom_range(0, 255));
    c.b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      c.r = 8'($urandom_range(0, 1));
      c.g = 8'($urandom_range(0, 1));
      c.b = 8'($urandom_range(0, 1));
    end
    if (pick < 30) begin
      c.op = OP_TICK;
      c.light = 8'($urandom_range(0, 255));
    end else if (pick < 50) begin
      c.op = OP_SET_MODE;
      if ($urandom_range(0, 9) < 4) c.mv = MODE_BLINK;
    end else if (pick < 75) begin
      c.op = OP_SET_COLOR;
    end else if (pick < 88) begin
      c.op = OP_TOGGLE;
    end else begin
      c.op = op_t'($urandom_range(1, 3));
      c.light = 8'($urandom_range(LIGHTS, 255));
    end
    return c;
  endfunction

  // Offer one command; valid stays up after acceptance for the next call
  task automatic send_command(cmd_t c);
    int gap;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    op = c.op;
    light = c.light;
    mode_value = c.mv;
    red = c.r;
    green = c.g;
    blue = c.b;
    now_ms = c.now;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_command(c);
    @(negedge clk);
  endtask

  // Drain outstanding results, then let any silent work finish
  task automatic settle();
    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_period(logic [15:0] p);
    cfg_data = p;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_period(p);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Result side: random stalls, one long hold on request
  initial begin
    int wait_n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        wait_n = HOLD;
        hold_req = 0;
      end else begin
        wait_n = take_idle ? $urandom_range(0, 14) : 0;
      end
      if (wait_n > 0) begin
        out_stall = 1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
      sb.check_pixel('{idx: out_light, r: out_red, g: out_green, b: out_blue,
                       bad: bad_light, last: frame_last});
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Main sequence: directed checks, then random phases over several periods
  initial begin
    cmd_t        dir [$];
    logic [15:0] plan [7];
    sb = new();
    rst = 1;
    cfg_valid = 0;
    cfg_data = 0;
    in_valid = 0;
    op = 0;
    light = 0;
    mode_value = 0;
    red = 0;
    green = 0;
    blue = 0;
    now_ms = 0;
    out_stall = 0;
    send_idle = 1;
    take_idle = 1;
    hold_req = 0;
    wall_ms = 0;
    repeat (7) @(negedge clk);
    rst = 0;

    // tick with nothing blinking, then every op and the color/mode corners
    dir.push_back(cmd_of(OP_TICK, 0, MODE_OFF, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_TOGGLE, 0, MODE_OFF, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_TOGGLE, 0, MODE_OFF, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_SET_COLOR, 1, MODE_OFF, 255, 255, 255, 32'd0));
    dir.push_back(cmd_of(OP_SET_COLOR, 2, MODE_OFF, 1, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_SET_COLOR, 3, MODE_OFF, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_SET_COLOR, 7, MODE_OTHER, 0, 1, 1, 32'hFFFF_FFFF));
    dir.push_back(cmd_of(OP_SET_MODE, 4, MODE_ON, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_SET_MODE, 4, MODE_OFF, 0, 0, 0, 32'd0));
    // inert mode: no frame on set, unchanged frame on toggle
    dir.push_back(cmd_of(OP_SET_MODE, 5, MODE_OTHER, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_TOGGLE, 5, MODE_OTHER, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_SET_COLOR, 5, MODE_OFF, 9, 9, 9, 32'd0));
    // blink: same phase no change, flip, toggle, recolor while blinking
    dir.push_back(cmd_of(OP_SET_MODE, 6, MODE_BLINK, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_TICK, 0, MODE_OFF, 0, 0, 0, 32'd499));
    dir.push_back(cmd_of(OP_TICK, 0, MODE_OFF, 0, 0, 0, 32'd500));
    dir.push_back(cmd_of(OP_TOGGLE, 6, MODE_OFF, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_TOGGLE, 6, MODE_OFF, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_SET_COLOR, 6, MODE_OFF, 0, 255, 0, 32'd0));
    dir.push_back(cmd_of(OP_TICK, 255, MODE_OTHER, 255, 255, 255, 32'hFFFF_FFFF));
    // light index out of range
    dir.push_back(cmd_of(OP_SET_MODE, LIGHTS, MODE_ON, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_SET_COLOR, 255, MODE_OTHER, 255, 255, 255, 32'd0));
    dir.push_back(cmd_of(OP_TOGGLE, 200, MODE_OFF, 0, 0, 0, 32'd0));
    dir.push_back(cmd_of(OP_TOGGLE, 64, MODE_OFF, 0, 0, 0, 32'd0));
    foreach (dir[i]) send_command(dir[i]);

    plan = '{PERIOD_RESET, 16'd1, 16'd0, 16'hFFFF, 16'd7,
             16'($urandom_range(2, 65534)), 16'd500};
    for (int k = 0; k < 7; k++) begin
      // first phase keeps the reset period
      if (k > 0) begin
        settle();
        write_period(plan[k]);
        wall_ms = $urandom;
      end
      send_idle = (k == 3) ? 0 : ($urandom_range(0, 3) != 0);
      take_idle = (k == 3) ? 0 : ($urandom_range(0, 3) != 0);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if ((k == 1 || k == 4) && j == 10) hold_req = 1;
        send_command(random_command(plan[k]));
      end
    end

    in_valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule
